/* rtl/grid_bicubic_bilinear_interp_core_assert.svh */
// assertion macros shared by the rtl of the grid interpolator
`ifndef GRID_BICUBIC_BILINEAR_INTERP_CORE_ASSERT_SVH
`define GRID_BICUBIC_BILINEAR_INTERP_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define GBI_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("gbi assertion failed");
`define GBI_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) ante |=> cons) \
      else $error("gbi assertion failed");
`else
`define GBI_ASSERT(label, clk, rst, prop)
`define GBI_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

/* rtl/gbi_pkg.sv */
// types, constants and weight functions of the grid interpolator
`timescale 1ns / 1ps
package gbi_pkg;

   localparam int FRAC_BITS   = 16;
   localparam int SAMPLE_BITS = 32;
   localparam int COORD_W     = 32;
   localparam int GDIM_W      = 7;
   localparam int WGT_W       = 20;
   localparam int ROW_W       = 38;
   localparam int MUL_A_W     = ROW_W;
   localparam int PROD_W      = MUL_A_W + WGT_W;
   localparam int ACC_W       = PROD_W + 4;
   localparam int RND_SHIFT   = FRAC_BITS + 1;
   localparam int RES_W       = ACC_W - RND_SHIFT;
   localparam int T2_W        = FRAC_BITS + 1;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 32;

   localparam logic signed [ACC_W-1:0] RND_BIAS = ACC_W'(1) << (RND_SHIFT - 1);
   localparam logic signed [RES_W-1:0] RES_MAX  =
      (RES_W'(1) << (SAMPLE_BITS - 1)) - RES_W'(1);
   localparam logic signed [RES_W-1:0] RES_MIN  = -RES_MAX - RES_W'(1);
   localparam logic signed [WGT_W-1:0] WGT_TWO  = WGT_W'(1) << (FRAC_BITS + 1);

   localparam logic [CSR_IDX_W-1:0] CSR_MODE   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_WIDTH  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_HEIGHT = 2'd2;

   typedef enum logic [1:0] {
      CMD_WRITE    = 2'd0,
      CMD_EVAL     = 2'd1,
      CMD_EVAL_UNB = 2'd2,
      CMD_NONE     = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_POW,
      ST_WSET,
      ST_TAPS,
      ST_ROWWAIT,
      ST_COLS,
      ST_COLWAIT,
      ST_OUT
   } state_type;

   typedef logic signed [WGT_W-1:0] wgt_type;

   typedef struct packed {
      logic       valid;
      logic       first;
      logic       last;
      logic       col_pass;
      logic [1:0] tag;
   } mac_ctl_type;

   typedef struct packed {
      logic                    valid;
      logic                    col_pass;
      logic [1:0]              tag;
      logic signed [RES_W-1:0] value;
   } mac_res_type;

   // catmull-rom weights, doubled
   function automatic wgt_type cubic_wgt(input logic [1:0] k,
                                         input logic [FRAC_BITS-1:0] t,
                                         input logic [T2_W-1:0] t2,
                                         input logic [T2_W-1:0] t3);
      wgt_type st;
      wgt_type s2;
      wgt_type s3;
      wgt_type w;
      st = WGT_W'(t);
      s2 = WGT_W'(t2);
      s3 = WGT_W'(t3);
      case (k)
         2'd0: w = -s3 + (s2 <<< 1) - st;
         2'd1: w = (s3 <<< 1) + s3 - (s2 <<< 2) - s2 + WGT_TWO;
         2'd2: w = -(s3 <<< 1) - s3 + (s2 <<< 2) + st;
         default: w = s3 - s2;
      endcase
      return w;
   endfunction

   // linear weights, doubled
   function automatic wgt_type lin_wgt(input logic [1:0] k,
                                       input logic [FRAC_BITS-1:0] t);
      wgt_type st;
      wgt_type w;
      st = WGT_W'(t);
      case (k)
         2'd0: w = WGT_TWO - (st <<< 1);
         2'd1: w = st <<< 1;
         default: w = '0;
      endcase
      return w;
   endfunction

   function automatic logic [SAMPLE_BITS-1:0] sat_res(input logic signed [RES_W-1:0] v);
      logic [SAMPLE_BITS-1:0] r;
      if (v > RES_MAX) begin
         r = SAMPLE_BITS'(RES_MAX);
      end else if (v < RES_MIN) begin
         r = SAMPLE_BITS'(RES_MIN);
      end else begin
         r = SAMPLE_BITS'(v);
      end
      return r;
   endfunction

endpackage

/* rtl/gbi_req_if.sv */
// request channel of the grid interpolator
`timescale 1ns / 1ps
interface gbi_req_if import gbi_pkg::*;;
   logic                          valid;
   logic                          ready;
   logic [1:0]                    command;
   logic [5:0]                    write_row;
   logic [5:0]                    write_col;
   logic signed [SAMPLE_BITS-1:0] write_sample;
   logic signed [COORD_W-1:0]     coord_x;
   logic signed [COORD_W-1:0]     coord_y;

   modport source (output valid, command, write_row, write_col, write_sample,
                   coord_x, coord_y, input ready);
   modport sink (input valid, command, write_row, write_col, write_sample,
                 coord_x, coord_y, output ready);
endinterface

/* rtl/gbi_rsp_if.sv */
// result channel of the grid interpolator
`timescale 1ns / 1ps
interface gbi_rsp_if import gbi_pkg::*;;
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] interp_value;
   logic                          outside_rows;

   modport source (output valid, interp_value, outside_rows, input ready);
   modport sink (input valid, interp_value, outside_rows, output ready);
endinterface

/* rtl/gbi_csr_if.sv */
// register write channel of the grid interpolator
`timescale 1ns / 1ps
interface gbi_csr_if import gbi_pkg::*;;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

/* rtl/gbi_ram.sv */
// single-port ram with registered read
`timescale 1ns / 1ps
module gbi_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     en,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         if (we) begin
            mem_ff[addr] <= wdata;
         end else begin
            rdata_ff <= mem_ff[addr];
         end
      end
   end

   assign rdata = rdata_ff;
endmodule

/* rtl/gbi_mac.sv */
// shared multiplier with registered product and rounding accumulator
`timescale 1ns / 1ps
module gbi_mac import gbi_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  mac_ctl_type               ctl,
   input  logic signed [MUL_A_W-1:0] op_a,
   input  logic signed [WGT_W-1:0]   op_b,
   output logic signed [PROD_W-1:0]  prod,
   output mac_res_type               res
);
   logic signed [PROD_W-1:0] prod_ff;
   logic signed [PROD_W-1:0] prod_in;
   mac_ctl_type              s1_ff;
   logic signed [ACC_W-1:0]  acc_ff;
   logic signed [ACC_W-1:0]  sum_in;
   mac_res_type              res_ff;
   mac_res_type              res_in;

   assign prod_in = PROD_W'(op_a) * PROD_W'(op_b);

   // each pass starts from the half-lsb bias, so the final shift rounds half up
   always_comb begin
      sum_in = (s1_ff.first ? RND_BIAS : acc_ff) + ACC_W'(prod_ff);
      res_in.valid    = s1_ff.valid && s1_ff.last;
      res_in.col_pass = s1_ff.col_pass;
      res_in.tag      = s1_ff.tag;
      res_in.value    = RES_W'(sum_in >>> RND_SHIFT);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff  <= '0;
         res_ff <= '0;
      end else begin
         s1_ff  <= ctl;
         res_ff <= res_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      if (s1_ff.valid) begin
         acc_ff <= sum_in;
      end
   end

   assign prod = prod_ff;
   assign res  = res_ff;
endmodule

/* rtl/grid_bicubic_bilinear_interp_core.sv */
// top level of the grid interpolator: sequencer, registers and result stage
`timescale 1ns / 1ps
`include "grid_bicubic_bilinear_interp_core_assert.svh"
// Interpolating lookup into a MAX_ROWS x MAX_COLS grid of signed Q16.16
// samples held in one single-port ram. A write beat stores one sample and
// gives no result. An evaluate beat clamps the point into the grid
// (the unbounded form returns zero with outside_rows set when y leaves the
// rows), then runs either a Catmull-Rom pass (4x4 taps) or a bilinear pass
// (2x2 taps) through a single multiply-accumulate unit, one tap per cycle,
// followed by the column pass over the row results. The sample store has no
// reset; a point whose taps touch never-written entries gives an undefined
// value. The time an evaluate takes is set by the serial read of the taps
// from the single ram port and the shared multiplier, which in bicubic mode
// first forms the squares and cubes of the fractions. The block takes no
// new beat while an evaluate is in progress; a finished result waits in the
// output register and does not stop the next beat from being taken.
module grid_bicubic_bilinear_interp_core import gbi_pkg::*; #(
   parameter int MAX_COLS = 64,
   parameter int MAX_ROWS = 64
) (
   input logic        clock,
   input logic        reset,
   gbi_req_if.sink    req_bus,
   gbi_rsp_if.source  rsp_bus,
   gbi_csr_if.sink    csr_bus
);
   localparam int DEPTH  = MAX_ROWS * MAX_COLS;
   localparam int AW     = $clog2(DEPTH);
   localparam int GW_RST = (MAX_COLS < 64) ? MAX_COLS : 64;
   localparam int GH_RST = (MAX_ROWS < 64) ? MAX_ROWS : 64;
   localparam int TI_W   = GDIM_W + 1;

   // ---------------- configuration registers ----------------
   logic              mode_ff;
   logic [GDIM_W-1:0] gw_ff;
   logic [GDIM_W-1:0] gh_ff;

   // out-of-range sizes saturate into [2, max]
   function automatic logic [GDIM_W-1:0] clamp_dim(input logic [GDIM_W-1:0] v,
                                                   input int lim);
      logic [GDIM_W-1:0] r;
      if (v < GDIM_W'(2)) begin
         r = GDIM_W'(2);
      end else if (int'(v) > lim) begin
         r = GDIM_W'(lim);
      end else begin
         r = v;
      end
      return r;
   endfunction

   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= 1'b1;
         gw_ff   <= GDIM_W'(GW_RST);
         gh_ff   <= GDIM_W'(GH_RST);
      end else if (csr_bus.valid) begin
         case (csr_bus.index)
            CSR_MODE:   mode_ff <= csr_bus.data[0];
            CSR_WIDTH:  gw_ff   <= clamp_dim(csr_bus.data[GDIM_W-1:0], MAX_COLS);
            CSR_HEIGHT: gh_ff   <= clamp_dim(csr_bus.data[GDIM_W-1:0], MAX_ROWS);
            default: ;
         endcase
      end
   end

   // ---------------- sequencer state ----------------
   state_type               state_ff;
   state_type               state_in;
   logic [2:0]              step_ff;
   logic [1:0]              tap_r_ff;
   logic [1:0]              tap_c_ff;
   logic [2:0]              rows_done_ff;
   mac_ctl_type             a_ctl_ff;
   logic                    a_skip_ff;
   wgt_type                 a_w_ff;

   // captured point
   logic [GDIM_W-1:0]       xi_ff;
   logic [GDIM_W-1:0]       yi_ff;
   logic [FRAC_BITS-1:0]    dx_ff;
   logic [FRAC_BITS-1:0]    dy_ff;
   logic                    cubic_ff;
   logic [T2_W-1:0]         x2_ff;
   logic [T2_W-1:0]         y2_ff;
   logic [T2_W-1:0]         x3_ff;
   logic [T2_W-1:0]         y3_ff;
   wgt_type                 wx_ff [4];
   wgt_type                 wy_ff [4];
   logic signed [ROW_W-1:0] rows_ff [4];
   logic [SAMPLE_BITS-1:0]  fin_val_ff;
   logic                    fin_out_ff;

   // result stage
   logic                    rsp_valid_ff;
   logic [SAMPLE_BITS-1:0]  rsp_value_ff;
   logic                    rsp_outside_ff;

   // ---------------- request decode and clamping ----------------
   cmd_type                   cmd;
   logic                      req_acc;
   logic                      is_eval;
   logic signed [COORD_W-1:0] xmax;
   logic signed [COORD_W-1:0] ymax;
   logic signed [COORD_W-1:0] xc;
   logic signed [COORD_W-1:0] yc;
   logic                      y_outside;
   logic [GDIM_W-1:0]         xi_new;
   logic [GDIM_W-1:0]         yi_new;
   logic                      cubic_new;
   logic                      wr_ok;
   logic [AW-1:0]             wr_addr;

   assign req_bus.ready = (state_ff == ST_IDLE);
   assign req_acc = req_bus.valid && req_bus.ready;

   always_comb begin
      cmd     = cmd_type'(req_bus.command);
      is_eval = (cmd == CMD_EVAL) || (cmd == CMD_EVAL_UNB);
      xmax    = COORD_W'(gw_ff - GDIM_W'(1)) << FRAC_BITS;
      ymax    = COORD_W'(gh_ff - GDIM_W'(1)) << FRAC_BITS;
      y_outside = (req_bus.coord_y < 0) || (req_bus.coord_y > ymax);

      if (req_bus.coord_x < 0) begin
         xc = '0;
      end else if (req_bus.coord_x > xmax) begin
         xc = xmax;
      end else begin
         xc = req_bus.coord_x;
      end
      if (req_bus.coord_y < 0) begin
         yc = '0;
      end else if (req_bus.coord_y > ymax) begin
         yc = ymax;
      end else begin
         yc = req_bus.coord_y;
      end
      xi_new = xc[FRAC_BITS +: GDIM_W];
      yi_new = yc[FRAC_BITS +: GDIM_W];

      // cubic needs the full 4x4 neighborhood two cells away from each edge
      cubic_new = mode_ff &&
                  (xi_new >= GDIM_W'(2)) && (TI_W'(xi_new) + TI_W'(4) <= TI_W'(gw_ff)) &&
                  (yi_new >= GDIM_W'(2)) && (TI_W'(yi_new) + TI_W'(4) <= TI_W'(gh_ff));

      // writes beyond the store are dropped
      wr_ok   = (int'(req_bus.write_row) < MAX_ROWS) && (int'(req_bus.write_col) < MAX_COLS);
      wr_addr = AW'(AW'(req_bus.write_row) * AW'(MAX_COLS) + AW'(req_bus.write_col));
   end

   // ---------------- tap address generation ----------------
   logic [1:0]      last_idx;
   logic [TI_W-1:0] tap_row;
   logic [TI_W-1:0] tap_col;
   wgt_type         wx_sel;
   wgt_type         wy_sel;
   logic            tap_skip;
   logic [AW-1:0]   tap_addr;

   always_comb begin
      last_idx = cubic_ff ? 2'd3 : 2'd1;
      // cubic taps start one cell before the base cell
      tap_row  = TI_W'(yi_ff) + TI_W'(tap_r_ff) - TI_W'(cubic_ff);
      tap_col  = TI_W'(xi_ff) + TI_W'(tap_c_ff) - TI_W'(cubic_ff);
      wx_sel   = wx_ff[tap_c_ff];
      wy_sel   = wy_ff[tap_r_ff];
      // zero-weight taps and taps past the last row or column add nothing
      tap_skip = (wx_sel == '0) || (wy_sel == '0) ||
                 (tap_row >= TI_W'(gh_ff)) || (tap_col >= TI_W'(gw_ff));
      tap_addr = AW'(AW'(tap_row) * AW'(MAX_COLS) + AW'(tap_col));
   end

   // ---------------- sample store ----------------
   logic                   ram_we;
   logic                   ram_re;
   logic [SAMPLE_BITS-1:0] ram_rdata;

   assign ram_we = req_acc && (cmd == CMD_WRITE) && wr_ok;
   assign ram_re = (state_ff == ST_TAPS) && !tap_skip;

   gbi_ram #(
      .WIDTH (SAMPLE_BITS),
      .DEPTH (DEPTH)
   ) u_grid (
      .clock (clock),
      .en    (ram_we || ram_re),
      .we    (ram_we),
      .addr  (ram_we ? wr_addr : tap_addr),
      .wdata (req_bus.write_sample),
      .rdata (ram_rdata)
   );

   // ---------------- shared multiply-accumulate ----------------
   mac_ctl_type              mac_ctl;
   mac_ctl_type              col_ctl;
   logic signed [MUL_A_W-1:0] mac_a;
   wgt_type                  mac_b;
   logic signed [PROD_W-1:0] mac_prod;
   mac_res_type              mac_res;
   logic [T2_W-1:0]          pow_rnd;

   // product of a fraction power, rounded half up back to the fraction format
   assign pow_rnd = T2_W'((mac_prod + PROD_W'(1 << (FRAC_BITS - 1))) >>> FRAC_BITS);

   always_comb begin
      if (a_ctl_ff.valid) begin
         // row pass: sample times column weight
         mac_ctl = a_ctl_ff;
         mac_a   = a_skip_ff ? '0 : MUL_A_W'($signed(ram_rdata));
         mac_b   = a_w_ff;
      end else if (state_ff == ST_COLS) begin
         // column pass: row result times row weight
         mac_ctl = col_ctl;
         mac_a   = rows_ff[tap_r_ff];
         mac_b   = wy_ff[tap_r_ff];
      end else begin
         // squares and cubes of the fractions, x and y interleaved
         mac_ctl = '0;
         case (step_ff)
            3'd1: begin
               mac_a = MUL_A_W'(dy_ff);
               mac_b = WGT_W'(dy_ff);
            end
            3'd2: begin
               mac_a = MUL_A_W'(x2_ff);
               mac_b = WGT_W'(dx_ff);
            end
            3'd3: begin
               mac_a = MUL_A_W'(y2_ff);
               mac_b = WGT_W'(dy_ff);
            end
            default: begin
               mac_a = MUL_A_W'(dx_ff);
               mac_b = WGT_W'(dx_ff);
            end
         endcase
      end
   end

   gbi_mac u_mac (
      .clock (clock),
      .reset (reset),
      .ctl   (mac_ctl),
      .op_a  (mac_a),
      .op_b  (mac_b),
      .prod  (mac_prod),
      .res   (mac_res)
   );

   // ---------------- next state ----------------
   always_comb begin
      state_in = state_ff;
      col_ctl  = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_acc && is_eval) begin
               if ((cmd == CMD_EVAL_UNB) && y_outside) begin
                  state_in = ST_OUT;
               end else if (cubic_new) begin
                  state_in = ST_POW;
               end else begin
                  state_in = ST_WSET;
               end
            end
         end
         ST_POW: begin
            if (step_ff == 3'd4) begin
               state_in = ST_WSET;
            end
         end
         ST_WSET: begin
            state_in = ST_TAPS;
         end
         ST_TAPS: begin
            if ((tap_r_ff == last_idx) && (tap_c_ff == last_idx)) begin
               state_in = ST_ROWWAIT;
            end
         end
         ST_ROWWAIT: begin
            if (rows_done_ff == 3'(last_idx) + 3'd1) begin
               state_in = ST_COLS;
            end
         end
         ST_COLS: begin
            col_ctl.valid    = 1'b1;
            col_ctl.first    = (tap_r_ff == 2'd0);
            col_ctl.last     = (tap_r_ff == last_idx);
            col_ctl.col_pass = 1'b1;
            col_ctl.tag      = tap_r_ff;
            if (tap_r_ff == last_idx) begin
               state_in = ST_COLWAIT;
            end
         end
         ST_COLWAIT: begin
            if (mac_res.valid && mac_res.col_pass) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // ---------------- control registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         tap_r_ff     <= '0;
         tap_c_ff     <= '0;
         rows_done_ff <= '0;
         a_ctl_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;

         a_ctl_ff <= '{valid:    (state_ff == ST_TAPS),
                       first:    (tap_c_ff == 2'd0),
                       last:     (tap_c_ff == last_idx),
                       col_pass: 1'b0,
                       tag:      tap_r_ff};

         case (state_ff)
            ST_IDLE: begin
               step_ff      <= '0;
               rows_done_ff <= '0;
            end
            ST_POW:  step_ff <= step_ff + 3'd1;
            ST_WSET: begin
               tap_r_ff <= '0;
               tap_c_ff <= '0;
            end
            ST_TAPS: begin
               if (tap_c_ff == last_idx) begin
                  tap_c_ff <= '0;
                  tap_r_ff <= tap_r_ff + 2'd1;
               end else begin
                  tap_c_ff <= tap_c_ff + 2'd1;
               end
            end
            ST_ROWWAIT: tap_r_ff <= '0;
            ST_COLS:    tap_r_ff <= tap_r_ff + 2'd1;
            default: ;
         endcase

         if (mac_res.valid && !mac_res.col_pass) begin
            rows_done_ff <= rows_done_ff + 3'd1;
         end

         if ((state_ff == ST_OUT) && (!rsp_valid_ff || rsp_bus.ready)) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // ---------------- datapath registers ----------------
   always_ff @(posedge clock) begin
      if (req_acc && is_eval) begin
         xi_ff      <= xi_new;
         yi_ff      <= yi_new;
         dx_ff      <= xc[FRAC_BITS-1:0];
         dy_ff      <= yc[FRAC_BITS-1:0];
         cubic_ff   <= cubic_new;
         fin_val_ff <= '0;
         fin_out_ff <= 1'b1;
      end

      if (state_ff == ST_POW) begin
         case (step_ff)
            3'd1: x2_ff <= pow_rnd;
            3'd2: y2_ff <= pow_rnd;
            3'd3: x3_ff <= pow_rnd;
            3'd4: y3_ff <= pow_rnd;
            default: ;
         endcase
      end

      if (state_ff == ST_WSET) begin
         for (int k = 0; k < 4; k++) begin
            wx_ff[k] <= cubic_ff ? cubic_wgt(2'(k), dx_ff, x2_ff, x3_ff)
                                 : lin_wgt(2'(k), dx_ff);
            wy_ff[k] <= cubic_ff ? cubic_wgt(2'(k), dy_ff, y2_ff, y3_ff)
                                 : lin_wgt(2'(k), dy_ff);
         end
      end

      a_skip_ff <= tap_skip;
      a_w_ff    <= wx_sel;

      if (mac_res.valid && !mac_res.col_pass) begin
         rows_ff[mac_res.tag] <= ROW_W'(mac_res.value);
      end
      if (mac_res.valid && mac_res.col_pass) begin
         fin_val_ff <= sat_res(mac_res.value);
         fin_out_ff <= 1'b0;
      end

      if ((state_ff == ST_OUT) && (!rsp_valid_ff || rsp_bus.ready)) begin
         rsp_value_ff   <= fin_val_ff;
         rsp_outside_ff <= fin_out_ff;
      end
   end

   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.interp_value = rsp_value_ff;
   assign rsp_bus.outside_rows = rsp_outside_ff;

   // ---------------- checks ----------------
   `GBI_ASSERT(a_ram_we_idle, clock, reset, ram_we |-> (state_ff == ST_IDLE))
   `GBI_ASSERT(a_outside_zero, clock, reset, (rsp_valid_ff && rsp_outside_ff) |-> (rsp_value_ff == '0))
   `GBI_ASSERT(a_rows_bound, clock, reset, rows_done_ff <= 3'd4)
   `GBI_ASSERT_NEXT(a_col_res_out, clock, reset, (mac_res.valid && mac_res.col_pass), (state_ff == ST_OUT))
endmodule

/* sim/tb.sv */
// self-checking testbench of the grid interpolator core
`timescale 1ns / 1ps
module tb;
   import gbi_pkg::*;

   // one request beat as the driver sees it
   typedef struct {
      cmd_type            command;
      logic [5:0]         write_row;
      logic [5:0]         write_col;
      logic signed [31:0] write_sample;
      logic signed [31:0] coord_x;
      logic signed [31:0] coord_y;
   } req_beat_type;

   // one expected result beat
   typedef struct {
      logic signed [31:0] interp_value;
      logic               outside_rows;
   } rsp_beat_type;

   localparam int NCOLS     = 64;
   localparam int NROWS     = 64;
   localparam int IDLE_PCT  = 17;
   localparam int SETTLE    = 60;     // longest evaluate plus margin
   localparam int WDOG_MAX  = 20000;  // cycles with no beat on any channel

   logic clock = 1'b0;
   logic reset = 1'b1;

   gbi_req_if req_bus ();
   gbi_rsp_if rsp_bus ();
   gbi_csr_if csr_bus ();

   grid_bicubic_bilinear_interp_core dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   always #5 clock = ~clock;

   // predicted state of the block
   longint sample_mem [NROWS*NCOLS];
   bit     written    [NROWS*NCOLS];
   bit     cubic_on;
   longint cols_used;
   longint rows_used;

   req_beat_type pending_beats[$];
   rsp_beat_type expected_rsps[$];

   int  errors     = 0;
   bit  calm       = 1'b0;   // no idling on either side
   int  rsp_hold   = 0;      // cycles the receiver still refuses results
   int  quiet_cnt  = 0;

   // ---------------------------------------------------------------- predictor

   function automatic longint grid_tap(longint r, longint c);
      if (r < 0 || c < 0 || r >= rows_used || c >= cols_used) return 0;
      return sample_mem[r*NCOLS + c];
   endfunction

   // catmull-rom weights, kept doubled
   function automatic void cubic_wgts(longint t, output longint w[4]);
      longint t2;
      longint t3;
      t2 = (t * t + 32768) >>> 16;
      t3 = (t2 * t + 32768) >>> 16;
      w[0] = -t3 + 2*t2 - t;
      w[1] = 3*t3 - 5*t2 + 2*65536;
      w[2] = -3*t3 + 4*t2 + t;
      w[3] = t3 - t2;
   endfunction

   // exact weighted sum, rounded half up once
   function automatic longint round_sum(longint v[4], longint w[4], int n);
      logic signed [127:0] acc;
      acc = 0;
      for (int k = 0; k < n; k++) acc = acc + v[k] * w[k];
      return longint'((acc + 128'sd65536) >>> 17);
   endfunction

   function automatic longint interp_at(longint x, longint y);
      longint xi, yi, dx, dy;
      longint rowv[4], taps[4], wx[4], wy[4];
      xi = x >>> 16;
      yi = y >>> 16;
      dx = x & 65535;
      dy = y & 65535;
      if (dx == 0 && dy == 0) return grid_tap(yi, xi);
      // cubic only away from the edges
      if (cubic_on && xi >= 2 && xi <= cols_used - 4 && yi >= 2 && yi <= rows_used - 4) begin
         cubic_wgts(dx, wx);
         cubic_wgts(dy, wy);
         for (int r = 0; r < 4; r++) begin
            for (int c = 0; c < 4; c++) taps[c] = grid_tap(yi - 1 + r, xi - 1 + c);
            rowv[r] = round_sum(taps, wx, 4);
         end
         return round_sum(rowv, wy, 4);
      end
      wx = '{2*(65536 - dx), 2*dx, 0, 0};
      wy = '{2*(65536 - dy), 2*dy, 0, 0};
      for (int r = 0; r < 2; r++) begin
         // zero-weight taps past the edge are skipped
         for (int c = 0; c < 4; c++)
            taps[c] = (c < 2 && wx[c] != 0 && wy[r] != 0) ? grid_tap(yi + r, xi + c) : 0;
         rowv[r] = round_sum(taps, wx, 2);
      end
      rowv[2] = 0;
      rowv[3] = 0;
      return round_sum(rowv, wy, 2);
   endfunction

   function automatic void predict_beat(req_beat_type b);
      longint x, y, xmax, ymax, v;
      rsp_beat_type e;
      if (b.command == CMD_WRITE) begin
         sample_mem[b.write_row*NCOLS + b.write_col] = longint'(b.write_sample);
         return;
      end
      if (b.command == CMD_NONE) return;
      x = b.coord_x;
      y = b.coord_y;
      xmax = (cols_used - 1) * 65536;
      ymax = (rows_used - 1) * 65536;
      if (b.command == CMD_EVAL_UNB && (y < 0 || y > ymax)) begin
         e.interp_value = '0;
         e.outside_rows = 1'b1;
      end else begin
         y = (y < 0) ? 0 : (y > ymax ? ymax : y);
         x = (x < 0) ? 0 : (x > xmax ? xmax : x);
         v = interp_at(x, y);
         v = (v > 64'sh7fffffff) ? 64'sh7fffffff : (v < -64'sh80000000 ? -64'sh80000000 : v);
         e.interp_value = v[31:0];
         e.outside_rows = 1'b0;
      end
      expected_rsps.push_back(e);
   endfunction

   // ----------------------------------------------------------- driver

   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else begin
         req_beat_type b;
         if (req_bus.valid && req_bus.ready) begin
            b.command      = cmd_type'(req_bus.command);
            b.write_row    = req_bus.write_row;
            b.write_col    = req_bus.write_col;
            b.write_sample = req_bus.write_sample;
            b.coord_x      = req_bus.coord_x;
            b.coord_y      = req_bus.coord_y;
            predict_beat(b);
         end
         if (!req_bus.valid || req_bus.ready) begin
            if (pending_beats.size() > 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
               b = pending_beats.pop_front();
               req_bus.command      <= b.command;
               req_bus.write_row    <= b.write_row;
               req_bus.write_col    <= b.write_col;
               req_bus.write_sample <= b.write_sample;
               req_bus.coord_x      <= b.coord_x;
               req_bus.coord_y      <= b.coord_y;
               req_bus.valid        <= 1'b1;
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // ----------------------------------------------------------- monitor

   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_beat_type e;
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expected_rsps.size() == 0) begin
               $error("result beat with nothing expected: interp_value %0d", rsp_bus.interp_value);
               errors++;
            end else begin
               e = expected_rsps.pop_front();
               if (rsp_bus.interp_value !== e.interp_value) begin
                  $error("interp_value expected %0d actual %0d", e.interp_value,
                         rsp_bus.interp_value);
                  errors++;
               end
               if (rsp_bus.outside_rows !== e.outside_rows) begin
                  $error("outside_rows expected %0d actual %0d", e.outside_rows,
                         rsp_bus.outside_rows);
                  errors++;
               end
            end
         end
         // long hold-off backs the block up into its input
         if (rsp_hold > 0) begin
            rsp_hold <= rsp_hold - 1;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
         end
      end
   end

   // ----------------------------------------------------------- watchdog

   always @(posedge clock) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
          (csr_bus.valid && csr_bus.ready) || reset) begin
         quiet_cnt <= 0;
      end else begin
         quiet_cnt <= quiet_cnt + 1;
      end
      if (quiet_cnt >= WDOG_MAX) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // ----------------------------------------------------------- stimulus

   // register write, only while the block is idle
   task automatic csr_write(logic [CSR_IDX_W-1:0] idx, logic [31:0] value);
      longint v;
      csr_bus.index <= idx;
      csr_bus.data  <= value;
      csr_bus.valid <= 1'b1;
      do @(posedge clock); while (!csr_bus.ready);
      csr_bus.valid <= 1'b0;
      v = value & 32'h7f;
      case (idx)
         CSR_MODE:   cubic_on = value[0];
         CSR_WIDTH:  cols_used = v < 2 ? 2 : (v > NCOLS ? NCOLS : v);
         CSR_HEIGHT: rows_used = v < 2 ? 2 : (v > NROWS ? NROWS : v);
         default: ;
      endcase
      @(posedge clock);
   endtask

   // block until every queued beat went out and every result came back
   task automatic drain();
      while (pending_beats.size() > 0 || req_bus.valid || expected_rsps.size() > 0)
         @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   function automatic req_beat_type write_beat(int r, int c, logic signed [31:0] s);
      req_beat_type b;
      b.command = CMD_WRITE;
      b.write_row = 6'(r);
      b.write_col = 6'(c);
      b.write_sample = s;
      b.coord_x = $urandom;
      b.coord_y = $urandom;
      written[r*NCOLS + c] = 1'b1;
      return b;
   endfunction

   function automatic req_beat_type eval_beat(cmd_type cmd, logic signed [31:0] x,
                                              logic signed [31:0] y);
      req_beat_type b;
      b.command = cmd;
      b.write_row = $urandom;
      b.write_col = $urandom;
      b.write_sample = $urandom;
      b.coord_x = x;
      b.coord_y = y;
      return b;
   endfunction

   // coordinate mostly near the grid, sometimes on a node, sometimes anywhere
   function automatic logic signed [31:0] rand_coord(longint span);
      int pick;
      longint ip;
      pick = $urandom_range(99);
      if (pick < 20) return $urandom;
      ip = longint'($urandom_range(span + 3)) - 2;
      if (pick < 35) return 32'(ip * 65536);
      return 32'(ip * 65536 + $urandom_range(65535));
   endfunction

   function automatic logic signed [31:0] rand_sample();
      case ($urandom_range(9))
         0: return 32'sh7fffffff;
         1: return 32'sh80000000;
         2: return 32'($urandom_range(131072)) - 32'sd65536;
         default: return $urandom;
      endcase
   endfunction

   // write every entry of the grid in use that was never written
   task automatic fill_grid(int w, int h);
      for (int r = 0; r < h; r++)
         for (int c = 0; c < w; c++)
            if (!written[r*NCOLS + c]) pending_beats.push_back(write_beat(r, c, rand_sample()));
   endtask

   task automatic random_beats(int n);
      int pick;
      for (int i = 0; i < n; i++) begin
         pick = $urandom_range(99);
         if (pick < 18)
            pending_beats.push_back(write_beat($urandom_range(63), $urandom_range(63),
                                               rand_sample()));
         else if (pick < 21)
            pending_beats.push_back(eval_beat(CMD_NONE, $urandom, $urandom));
         else
            pending_beats.push_back(eval_beat(pick < 60 ? CMD_EVAL : CMD_EVAL_UNB,
                                              rand_coord(cols_used), rand_coord(rows_used)));
      end
   endtask

   // one phase: registers, grid fill, then random traffic
   task automatic run_phase(logic [31:0] mode, logic [31:0] w, logic [31:0] h, int n);
      csr_write(CSR_MODE, mode);
      csr_write(CSR_WIDTH, w);
      csr_write(CSR_HEIGHT, h);
      fill_grid(int'(cols_used), int'(rows_used));
      random_beats(n);
      drain();
   endtask

   initial begin
      cubic_on  = 1'b1;
      cols_used = 64;
      rows_used = 64;
      foreach (written[i]) written[i] = 1'b0;
      foreach (sample_mem[i]) sample_mem[i] = 0;
      req_bus.valid = 1'b0;
      req_bus.command = CMD_NONE;
      req_bus.write_row = '0;
      req_bus.write_col = '0;
      req_bus.write_sample = '0;
      req_bus.coord_x = '0;
      req_bus.coord_y = '0;
      rsp_bus.ready = 1'b0;
      csr_bus.valid = 1'b0;
      csr_bus.index = CSR_MODE;
      csr_bus.data = '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: 8x8 cubic grid, corners and special cases
      csr_write(CSR_MODE, 32'd1);
      csr_write(CSR_WIDTH, 32'd8);
      csr_write(CSR_HEIGHT, 32'd8);
      fill_grid(8, 8);
      pending_beats.push_back(write_beat(0, 0, 32'sh7fffffff));
      pending_beats.push_back(write_beat(7, 7, 32'sh80000000));
      pending_beats.push_back(write_beat(63, 63, 32'sh12345678));   // outside the grid in use
      pending_beats.push_back(eval_beat(CMD_EVAL, 32'sh0, 32'sh0));  // node
      pending_beats.push_back(eval_beat(CMD_EVAL, 32'sh7fffffff, 32'sh7fffffff));
      pending_beats.push_back(eval_beat(CMD_EVAL, 32'sh80000000, 32'sh80000000));
      pending_beats.push_back(eval_beat(CMD_EVAL, 32'sh0003_8000, 32'sh0004_4000)); // cubic
      pending_beats.push_back(eval_beat(CMD_EVAL, 32'sh0004_ffff, 32'sh0002_0001)); // cubic
      pending_beats.push_back(eval_beat(CMD_EVAL, 32'sh0001_8000, 32'sh0003_8000)); // fallback
      pending_beats.push_back(eval_beat(CMD_EVAL, 32'sh0006_8000, 32'sh0006_c000)); // near edge
      pending_beats.push_back(eval_beat(CMD_EVAL, 32'sh0007_0000, 32'sh0006_8000)); // last col
      pending_beats.push_back(eval_beat(CMD_EVAL_UNB, 32'sh0002_0000, 32'shffff_ffff));
      pending_beats.push_back(eval_beat(CMD_EVAL_UNB, 32'sh0002_0000, 32'sh0007_0001));
      pending_beats.push_back(eval_beat(CMD_EVAL_UNB, 32'sh7fff_0000, 32'sh0007_0000));
      pending_beats.push_back(eval_beat(CMD_EVAL_UNB, 32'sh8000_0000, 32'sh0003_8000));
      pending_beats.push_back(eval_beat(CMD_NONE, 32'sh0003_8000, 32'sh0003_8000));
      pending_beats.push_back(eval_beat(CMD_EVAL, 32'sh0000_0001, 32'sh0007_0000));
      drain();

      // receiver holds off while the sender keeps offering evaluates
      random_beats(40);
      rsp_hold = 400;
      drain();

      // no idling at all for one stretch
      calm = 1'b1;
      random_beats(120);
      drain();
      calm = 1'b0;

      // smallest grid, bilinear; out-of-range register values saturate
      run_phase(32'd0, 32'd1, 32'd0, 80);
      // widest grid, one row of cells
      run_phase(32'd3, 32'h7f, 32'd2, 100);
      // tallest grid
      run_phase(32'd1, 32'd2, 32'd64, 100);
      run_phase(32'd1, 32'd12, 32'd10, 110);
      run_phase(32'd0, 32'd5, 32'd7, 70);
      run_phase(32'd1, 32'd4, 32'd4, 60);
      run_phase(32'd1, 32'd6, 32'd6, 40);

      if (errors == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
